// ===== src/dqd_pkg.sv =====
// ----------------------------------------------------------------------------
// dqd_pkg: shared types and constants of the double-ended queue
// Holds the queue depth, the opcode and status codes, and the control
// struct that the top level broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package dqd_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned OP_W    = 3;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DELETE     = 3'd4
  } opcode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  // Per-cycle command seen by every cell. At most one action bit is set.
  typedef struct packed {
    logic                     shift_r;    // push front: every cell takes its left neighbor
    logic                     append;     // push back: first free cell takes the value
    logic                     rm_start;   // removal starts at the head cell
    logic                     scan;       // removal starts at the first matching cell
    logic                     drop_tail;  // last occupied cell is released
    logic signed [DATA_W-1:0] value;      // pushed value or search key
  } dqd_ctrl_t;

endpackage

// ===== src/deque_with_delete_by_value.sv =====
// ----------------------------------------------------------------------------
// deque_with_delete_by_value: bounded double-ended queue with delete by value
// A row of storage cells that pushes, pops and deletes entries in place.
// ----------------------------------------------------------------------------
// The block keeps an ordered list of up to DEPTH signed 32-bit entries in a
// row of cells, the head in cell 0. Every accepted item is completed in the
// clock edge that accepts it, and its result is shown on the next cycle, so
// the block takes one item per cycle as long as results are taken promptly;
// a stalled result holds the input side until it is taken. The figure is set
// by the cell row: all cells compare against the key and move data to a
// neighbor in the same cycle, and the search for the first interior match
// ripples through the row from the head. A delete removes the head if it
// matches, else the tail if it matches, else the first match from the head.
// Reset empties the list; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
module deque_with_delete_by_value
  import dqd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic signed [DATA_W-1:0] operand_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [CNT_W-1:0]         entry_count_o,
  output logic signed [DATA_W-1:0] front_value_o,
  output logic signed [DATA_W-1:0] back_value_o,
  output logic [STAT_W-1:0]        status_o
);

  // Cell row signals.
  dqd_ctrl_t                ctrl;
  logic signed [DATA_W-1:0] cell_value [DEPTH];
  logic [DEPTH-1:0]         cell_valid;
  logic [DEPTH-1:0]         cell_match;
  logic [DEPTH-1:0]         cell_rm;
  logic [DEPTH-1:0]         is_tail;

  // Control and result registers.
  logic [CNT_W-1:0]  count_q, count_d;
  logic              out_valid_q;
  status_e           status_q, status_d;

  logic in_acc;
  logic full, empty;
  logic head_match, tail_match, any_match;
  logic signed [DATA_W-1:0] back_value;

  // The output register only frees up when its item is taken, so the
  // list state that the result reflects cannot change underneath it.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CNT_W'(DEPTH));
  assign empty = (count_q == '0);

  // The tail cell is the last occupied one; its right neighbor is free.
  always_comb begin
    back_value = '0;
    tail_match = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == DEPTH - 1) begin
        is_tail[i] = cell_valid[i];
      end else begin
        is_tail[i] = cell_valid[i] && !cell_valid[i+1];
      end
      if (is_tail[i]) begin
        back_value = back_value | cell_value[i];
        tail_match = tail_match | cell_match[i];
      end
    end
  end

  assign head_match = cell_match[0];
  assign any_match  = |cell_match;

  // Decode the item into one command for the cell row, plus the new count
  // and the status that goes out with the result.
  always_comb begin
    ctrl          = '0;
    ctrl.value    = operand_value_i;
    count_d       = count_q;
    status_d      = ST_DONE;
    if (in_acc) begin
      unique case (opcode_i)
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.shift_r = 1'b1;
            count_d      = count_q + CNT_W'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            ctrl.append = 1'b1;
            count_d     = count_q + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.rm_start = 1'b1;
            count_d       = count_q - CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            ctrl.drop_tail = 1'b1;
            count_d        = count_q - CNT_W'(1);
          end
        end
        OP_DELETE: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else if (!any_match) begin
            status_d = ST_NOT_FOUND;
          end else begin
            // Head match wins, then tail match, then the first interior one.
            if (head_match) begin
              ctrl.rm_start = 1'b1;
            end else if (tail_match) begin
              ctrl.drop_tail = 1'b1;
            end else begin
              ctrl.scan = 1'b1;
            end
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
          // Unused opcodes leave the list alone and report done.
        end
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_value, right_value;
    logic                     left_valid, right_valid, rm_in;

    if (i == 0) begin : g_head
      // The head cell sees the pushed value as its left neighbor.
      assign left_value = ctrl.value;
      assign left_valid = 1'b1;
      assign rm_in      = ctrl.rm_start;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign rm_in      = cell_rm[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    dqd_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_value_i  (left_value),
      .left_valid_i  (left_valid),
      .right_value_i (right_value),
      .right_valid_i (right_valid),
      .rm_i          (rm_in),
      .rm_o          (cell_rm[i]),
      .match_o       (cell_match[i]),
      .value_o       (cell_value[i]),
      .valid_o       (cell_valid[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
        status_q    <= status_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result fields come straight from the list state, which holds
  // still for as long as the result waits.
  assign out_valid_o   = out_valid_q;
  assign entry_count_o = count_q;
  assign front_value_o = cell_valid[0] ? cell_value[0] : '0;
  assign back_value_o  = back_value;
  assign status_o      = status_q;

  // The occupied flags always agree with the count.
  a_count_matches_cells : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q)
  ) else $error("occupied cells disagree with the entry count");

  // Occupied cells form an unbroken run from the head.
  a_cells_packed : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0
  ) else $error("occupied cells are not packed at the head");

  // A dropped push is only reported for a full list.
  a_full_status : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ST_FULL) |-> full
  ) else $error("full status reported while the list has room");

  // A push into a list with room grows it by exactly one.
  a_push_grows : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !full && (opcode_i == OP_PUSH_FRONT || opcode_i == OP_PUSH_BACK))
      |=> (count_q == $past(count_q) + CNT_W'(1))
  ) else $error("push did not add exactly one entry");

endmodule

// ===== src/dqd_cell.sv =====
// ----------------------------------------------------------------------------
// dqd_cell: one storage position of the queue
// Holds one entry and its occupied flag, compares it against the search
// key, and moves data to or from its neighbors as the command dictates.
// ----------------------------------------------------------------------------
module dqd_cell
  import dqd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dqd_ctrl_t                ctrl_i,
  input  logic signed [DATA_W-1:0] left_value_i,
  input  logic                     left_valid_i,
  input  logic signed [DATA_W-1:0] right_value_i,
  input  logic                     right_valid_i,
  input  logic                     rm_i,
  output logic                     rm_o,
  output logic                     match_o,
  output logic signed [DATA_W-1:0] value_o,
  output logic                     valid_o
);

  logic signed [DATA_W-1:0] value_q, value_d;
  logic                     valid_q, valid_d;
  logic                     rm_here;

  assign match_o = valid_q && (value_q == ctrl_i.value);
  // Once a removal point is found, every cell from there on shifts left.
  assign rm_here = rm_i || (ctrl_i.scan && match_o);
  assign rm_o    = rm_here;

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    priority if (ctrl_i.shift_r) begin
      value_d = left_value_i;
      valid_d = left_valid_i;
    end else if (ctrl_i.append) begin
      if (!valid_q && left_valid_i) begin
        value_d = ctrl_i.value;
        valid_d = 1'b1;
      end
    end else if (rm_here) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.drop_tail) begin
      if (valid_q && !right_valid_i) begin
        valid_d = 1'b0;
      end
    end else begin
      // No command touches this cell, so it keeps its entry.
      value_d = value_q;
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ===== verif/deque_with_delete_by_value_tb.sv =====
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_tb: self-checking bench for the bounded deque
// Feeds push, pop and delete items through the valid/stall input channel,
// keeps a shadow list that predicts every result, and checks each result
// field by field as it leaves the output channel. Both sides idle at random.
// ----------------------------------------------------------------------------
module deque_with_delete_by_value_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dqd_pkg::*;

  // Opcodes above the last defined one are legal on the port and must be
  // ignored by the block.
  localparam logic [OP_W-1:0] OP_UNUSED_FIRST = OP_W'(OP_DELETE) + OP_W'(1);
  localparam logic [OP_W-1:0] OP_UNUSED_LAST  = '1;

  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  localparam int KEY_POOL_SIZE    = 8;
  localparam int ITEMS_PER_PHASE  = 250;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 8;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int MAX_REPORTS      = 40;

  // One item on the input channel.
  typedef struct {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] value;
  } deque_cmd_t;

  // One result on the output channel.
  typedef struct {
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] back;
    status_e                  status;
  } deque_result_t;

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic [OP_W-1:0]          opcode_i        = '0;
  logic signed [DATA_W-1:0] operand_value_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic [CNT_W-1:0]         entry_count_o;
  logic signed [DATA_W-1:0] front_value_o;
  logic signed [DATA_W-1:0] back_value_o;
  logic [STAT_W-1:0]        status_o;

  deque_with_delete_by_value u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .operand_value_i (operand_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .entry_count_o   (entry_count_o),
    .front_value_o   (front_value_o),
    .back_value_o    (back_value_o),
    .status_o        (status_o)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Items waiting to be driven, and results predicted but not yet seen.
  deque_cmd_t    pending_cmds[$];
  deque_result_t expected_results[$];

  // Shadow copy of the list. Position 0 is the head.
  logic signed [DATA_W-1:0] shadow_list[DEPTH];
  int                       shadow_count;

  // Values that pushes and deletes draw from, so that deletes often hit.
  logic signed [DATA_W-1:0] key_pool[KEY_POOL_SIZE];

  // Idle rates in percent, set per phase by the stimulus process.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Long receiver hold-off, requested once by the stimulus process.
  logic hold_go   = 1'b0;
  logic long_hold = 1'b0;

  int         mismatch_count = 0;
  int         result_index   = 0;
  int         cycle_count    = 0;
  deque_cmd_t drive_cmd;

  // Applies one item to the shadow list and returns what the block should
  // report afterwards. Pops and deletes all end in a removal at one position;
  // the delete looks at the head, then the tail, then scans the interior from
  // the head, so a tail match wins over an interior one.
  function automatic deque_result_t apply_deque_op(logic [OP_W-1:0] op,
                                                   logic signed [DATA_W-1:0] val);
    deque_result_t res;
    int            hit;
    res.status = ST_DONE;
    hit = -1;
    case (op)
      OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = val;
          shadow_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_list[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == 0) res.status = ST_EMPTY;
        else hit = (op == OP_POP_FRONT) ? 0 : shadow_count - 1;
      end
      OP_DELETE: begin
        if (shadow_count == 0) begin
          res.status = ST_EMPTY;
        end else if (shadow_list[0] == val) begin
          hit = 0;
        end else if (shadow_list[shadow_count-1] == val) begin
          hit = shadow_count - 1;
        end else begin
          for (int i = 1; i < shadow_count - 1; i++) begin
            if (hit < 0 && shadow_list[i] == val) hit = i;
          end
          if (hit < 0) res.status = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    if (hit >= 0) begin
      for (int i = hit; i < shadow_count - 1; i++) shadow_list[i] = shadow_list[i+1];
      shadow_count--;
    end
    res.count = CNT_W'(shadow_count);
    res.front = (shadow_count == 0) ? '0 : shadow_list[0];
    res.back  = (shadow_count == 0) ? '0 : shadow_list[shadow_count-1];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch on result %0d: %s", $time, result_index, msg);
    end
  endtask

  // Driver. An accepted item is predicted at the edge that takes it. A new
  // item is offered only when the channel is free; a stalled one stays put.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i      <= 1'b0;
      opcode_i        <= '0;
      operand_value_i <= '0;
      shadow_count    = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_deque_op(opcode_i, operand_value_i));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drive_cmd = pending_cmds.pop_front();
          in_valid_i      <= 1'b1;
          opcode_i        <= drive_cmd.opcode;
          operand_value_i <= drive_cmd.value;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor. Checks each accepted result against the oldest prediction and
  // then picks the stall for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("no item outstanding, count %0d status %0d",
                                    entry_count_o, status_o));
        end else begin
          want = expected_results.pop_front();
          if (entry_count_o !== want.count)
            report_mismatch($sformatf("entry_count %0d, expected %0d",
                                      entry_count_o, want.count));
          if (front_value_o !== want.front)
            report_mismatch($sformatf("front_value %0d, expected %0d",
                                      front_value_o, want.front));
          if (back_value_o !== want.back)
            report_mismatch($sformatf("back_value %0d, expected %0d",
                                      back_value_o, want.back));
          if (status_o !== want.status)
            report_mismatch($sformatf("status %0d, expected %s",
                                      status_o, want.status.name()));
        end
        result_index++;
      end
      out_stall_i <= long_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // The receiver's long hold-off, counted here so the sender keeps offering
  // items while the block backs up and stalls its input.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    long_hold <= 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void queue_cmd(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] val);
    deque_cmd_t cmd;
    cmd.opcode = op;
    cmd.value  = val;
    pending_cmds.push_back(cmd);
  endfunction

  // Mostly pool values, so that deletes find matches and duplicates occur.
  function automatic logic signed [DATA_W-1:0] pick_value(int pool_pct);
    if ($urandom_range(99) < pool_pct) return key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Queues bursts until the given number of effective items is reached.
  // Fill bursts run the list into the full case, drain bursts run it down
  // toward empty, mixed bursts exercise everything, and noise bursts slip in
  // unused opcodes, which do not count.
  task automatic add_random_items(int target);
    int added;
    int kind;
    int len;
    added = 0;
    while (added < target) begin
      kind = (added == 0) ? 0 : $urandom_range(9);
      if (kind <= 2) begin
        len = DEPTH + $urandom_range(3, 1);
        repeat (len) begin
          queue_cmd($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value(60));
        end
      end else if (kind <= 5) begin
        len = DEPTH + $urandom_range(3, 1);
        repeat (len) begin
          case ($urandom_range(9))
            0, 1, 2: queue_cmd(OP_POP_FRONT, pick_value(0));
            3, 4, 5: queue_cmd(OP_POP_BACK, pick_value(0));
            default: queue_cmd(OP_DELETE, pick_value(80));
          endcase
        end
      end else if (kind <= 8) begin
        len = $urandom_range(24, 8);
        repeat (len) begin
          queue_cmd(OP_W'($urandom_range(OP_DELETE, OP_PUSH_FRONT)), pick_value(70));
        end
      end else begin
        len = 1;
        repeat ($urandom_range(3, 1)) begin
          queue_cmd(OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST)), $urandom);
        end
        queue_cmd(OP_W'($urandom_range(OP_DELETE, OP_PUSH_FRONT)), pick_value(70));
      end
      added += len;
    end
  endtask

  // Returns once every queued item has been taken and every result seen.
  task automatic wait_for_drain();
    do @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid_i || expected_results.size() != 0);
  endtask

  // Stimulus sequence and end of run.
  initial begin
    key_pool[0] = VAL_MIN;
    key_pool[1] = VAL_MAX;
    key_pool[2] = '0;
    key_pool[3] = -1;
    for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 62;

    // Directed part. Everything on an empty list is a no-op.
    queue_cmd(OP_POP_FRONT, '0);
    queue_cmd(OP_POP_BACK, '0);
    queue_cmd(OP_DELETE, VAL_MAX);
    // Build MIN, MAX, 0, -1 from both ends.
    queue_cmd(OP_PUSH_BACK, VAL_MAX);
    queue_cmd(OP_PUSH_FRONT, VAL_MIN);
    queue_cmd(OP_PUSH_BACK, '0);
    queue_cmd(OP_PUSH_BACK, -1);
    // A value that is nowhere in the list.
    queue_cmd(OP_DELETE, 32'sd5);
    // MIN at both ends: the head copy goes.
    queue_cmd(OP_PUSH_BACK, VAL_MIN);
    queue_cmd(OP_DELETE, VAL_MIN);
    // Zero in the interior and at the tail: the tail copy goes.
    queue_cmd(OP_PUSH_BACK, '0);
    queue_cmd(OP_DELETE, '0);
    // Interior match only.
    queue_cmd(OP_DELETE, -1);
    // Unused opcodes leave the list alone.
    queue_cmd(OP_UNUSED_FIRST, -1);
    queue_cmd(OP_UNUSED_LAST, VAL_MIN);
    // Shrink to one entry, delete it, then push and pop on a single entry.
    queue_cmd(OP_POP_FRONT, VAL_MAX);
    queue_cmd(OP_POP_BACK, VAL_MAX);
    queue_cmd(OP_DELETE, '0);
    queue_cmd(OP_PUSH_FRONT, -1);
    queue_cmd(OP_POP_BACK, '0);
    // The sender stops here until the list has caught up completely.
    wait_for_drain();

    add_random_items(ITEMS_PER_PHASE);
    wait_for_drain();

    send_idle_pct = 62;
    recv_idle_pct = 20;
    add_random_items(ITEMS_PER_PHASE);
    wait_for_drain();

    // No random idling; the long hold-off backs the block up instead.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_items(ITEMS_PER_PHASE);
    hold_go = 1'b1;
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
